[src/pvp_pkg.sv]
// Shared types and constants of the perspective vertex projector.
// Used by pvp_div_cell, the top level and the bench; depends on nothing.
`default_nettype none
package pvp_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CFG_ROW0_A  = 4'd0;
  localparam logic [3:0] CFG_ROW0_B  = 4'd1;
  localparam logic [3:0] CFG_ROW1_A  = 4'd2;
  localparam logic [3:0] CFG_ROW1_B  = 4'd3;
  localparam logic [3:0] CFG_ROW2_A  = 4'd4;
  localparam logic [3:0] CFG_ROW2_B  = 4'd5;
  localparam logic [3:0] CFG_WIDTH   = 4'd6;
  localparam logic [3:0] CFG_HEIGHT  = 4'd7;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COLOR_W    = 24;
  // Quotient bits resolved by the divider chain; the rest saturates.
  localparam int unsigned QUO_BITS   = 31;

  localparam logic [PIX_W-1:0]   PIX_MAX     = 32'h7FFF_FFFF;
  localparam logic [PIX_W-1:0]   PIX_MIN     = 32'h8000_0000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h00_0000;

  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd768;

  // How a coordinate is finished: by division, or fixed by a zero depth.
  typedef enum logic [1:0] {
    KIND_NORM = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_MIN  = 2'd2,
    KIND_MAX  = 2'd3
  } pvp_kind_e;

  // Control word that travels alongside the division data.
  typedef struct packed {
    pvp_kind_e kind_x;
    pvp_kind_e kind_y;
    logic      neg_x;
    logic      neg_y;
    logic      sat_x;
    logic      sat_y;
    logic      white;
    logic      last;
  } pvp_side_t;

endpackage
`default_nettype wire

[src/pvp_cam_row.sv]
// One row of the world-to-camera transform: three products and a sum.
// Two register stages; depends on nothing but its ports.
`default_nettype none
module pvp_cam_row #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned CAM_W      = 50
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic        [63:0]           coef_a_i,
  input  wire logic        [63:0]           coef_b_i,
  input  wire logic signed [COORD_BITS-1:0] vx_i,
  input  wire logic signed [COORD_BITS-1:0] vy_i,
  input  wire logic signed [COORD_BITS-1:0] vz_i,
  output logic signed      [CAM_W-1:0]      cam_o
);
  localparam int unsigned PR_W = 32 + COORD_BITS;

  logic signed [PR_W-1:0]  p0_q, p1_q, p2_q;
  logic signed [PR_W-1:0]  p0_d, p1_d, p2_d;
  logic signed [31:0]      t_q;
  logic signed [CAM_W-1:0] sum_d, sum_q;

  always_comb begin
    p0_d = PR_W'($signed(coef_a_i[31:0]) * vx_i);
    p1_d = PR_W'($signed(coef_a_i[63:32]) * vy_i);
    p2_d = PR_W'($signed(coef_b_i[31:0]) * vz_i);
  end

  // Sums wrap at the accumulator width, as a 64-bit accumulator would.
  assign sum_d = CAM_W'(p0_q) + CAM_W'(p1_q) + CAM_W'(p2_q) + CAM_W'(t_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      t_q   <= $signed(coef_b_i[63:32]);
      sum_q <= sum_d;
    end
  end

  assign cam_o = sum_q;
endmodule
`default_nettype wire

[src/pvp_div_cell.sv]
// One cell of the divider chain: one restoring step for each coordinate.
// Depends on pvp_pkg for the control word.
`default_nettype none
module pvp_div_cell #(
  parameter int unsigned D_W = 51,
  parameter int unsigned QB  = 31
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire pvp_pkg::pvp_side_t side_i,
  input  wire logic [D_W-1:0]    d_i,
  input  wire logic [D_W-1:0]    rx_i,
  input  wire logic [D_W-1:0]    ry_i,
  input  wire logic [QB-1:0]     px_i,
  input  wire logic [QB-1:0]     py_i,
  input  wire logic [QB-1:0]     qx_i,
  input  wire logic [QB-1:0]     qy_i,
  output logic                   valid_o,
  output pvp_pkg::pvp_side_t     side_o,
  output logic [D_W-1:0]         d_o,
  output logic [D_W-1:0]         rx_o,
  output logic [D_W-1:0]         ry_o,
  output logic [QB-1:0]          px_o,
  output logic [QB-1:0]          py_o,
  output logic [QB-1:0]          qx_o,
  output logic [QB-1:0]          qy_o
);
  logic [D_W:0]   rx2, ry2, dd, dfx, dfy;
  logic           gex, gey;
  logic [D_W-1:0] rx_d, ry_d;

  always_comb begin
    dd   = {1'b0, d_i};
    rx2  = {rx_i, px_i[QB-1]};
    ry2  = {ry_i, py_i[QB-1]};
    gex  = rx2 >= dd;
    gey  = ry2 >= dd;
    dfx  = rx2 - dd;
    dfy  = ry2 - dd;
    rx_d = gex ? dfx[D_W-1:0] : rx2[D_W-1:0];
    ry_d = gey ? dfy[D_W-1:0] : ry2[D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      d_o    <= d_i;
      rx_o   <= rx_d;
      ry_o   <= ry_d;
      px_o   <= {px_i[QB-2:0], 1'b0};
      py_o   <= {py_i[QB-2:0], 1'b0};
      qx_o   <= {qx_i[QB-2:0], gex};
      qy_o   <= {qy_i[QB-2:0], gey};
    end
  end
endmodule
`default_nettype wire

[src/perspective_vertex_projector.sv]
// Top level of the perspective vertex projector; depends on pvp_pkg,
// pvp_cam_row and pvp_div_cell.
`default_nettype none
// The projector takes one vertex per clock while its input is not stalled
// and returns one pixel word per vertex, in order. Two stages form the
// camera coordinates, three more form the magnitude, the scaled numerator
// and the saturation test, then a chain of 31 divider cells resolves one
// quotient bit each, and an output register finishes the word. A stall on
// the output freezes the whole pipeline, and the input is stalled only
// while a finished word waits. Configuration writes are always taken and
// must be made while no vertex is in flight.
module perspective_vertex_projector #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]  vertex_x_i,
  input  wire logic signed [COORD_BITS-1:0]  vertex_y_i,
  input  wire logic signed [COORD_BITS-1:0]  vertex_z_i,
  input  wire logic                          last_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [pvp_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [pvp_pkg::PIX_W-1:0]   pixel_y_o,
  output logic [pvp_pkg::COLOR_W-1:0]        color_o,
  output logic                               last_out_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pvp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]                   cfg_data_i
);
  localparam int unsigned CAM_W = (COORD_BITS + 34 > 64) ? 64 : COORD_BITS + 34;
  localparam int unsigned MAG_W = (CAM_W + 1 > 64) ? 64 : CAM_W + 1;
  localparam int unsigned D_W   = CAM_W + 1;
  localparam int unsigned QB    = pvp_pkg::QUO_BITS;
  localparam int unsigned PW    = MAG_W + pvp_pkg::SIZE_W;
  localparam int unsigned PH    = PW - QB;
  localparam int unsigned CW    = PH + D_W;
  localparam logic [63:0] ONE_FIXED = 64'd1 << FRAC_BITS;

  // Configuration registers.
  logic [63:0]                 mat_q [6];
  logic [pvp_pkg::SIZE_W-1:0]  width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= ONE_FIXED;
      mat_q[1] <= 64'd0;
      mat_q[2] <= ONE_FIXED << 32;
      mat_q[3] <= 64'd0;
      mat_q[4] <= 64'd0;
      mat_q[5] <= ONE_FIXED;
      width_q  <= pvp_pkg::WIDTH_RST;
      height_q <= pvp_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pvp_pkg::CFG_ROW0_A: mat_q[0] <= cfg_data_i;
        pvp_pkg::CFG_ROW0_B: mat_q[1] <= cfg_data_i;
        pvp_pkg::CFG_ROW1_A: mat_q[2] <= cfg_data_i;
        pvp_pkg::CFG_ROW1_B: mat_q[3] <= cfg_data_i;
        pvp_pkg::CFG_ROW2_A: mat_q[4] <= cfg_data_i;
        pvp_pkg::CFG_ROW2_B: mat_q[5] <= cfg_data_i;
        pvp_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[pvp_pkg::SIZE_W-1:0];
        pvp_pkg::CFG_HEIGHT: height_q <= cfg_data_i[pvp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a finished word is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stages one and two: camera coordinates.
  logic signed [CAM_W-1:0] cam [3];
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                    l1_q, l2_q, l3_q, l4_q, l5_q;

  for (genvar r = 0; r < 3; r++) begin : g_row
    pvp_cam_row #(
      .COORD_BITS (COORD_BITS),
      .CAM_W      (CAM_W)
    ) u_row (
      .clk_i    (clk_i),
      .en_i     (en),
      .coef_a_i (mat_q[2*r]),
      .coef_b_i (mat_q[2*r+1]),
      .vx_i     (vertex_x_i),
      .vy_i     (vertex_y_i),
      .vz_i     (vertex_z_i),
      .cam_o    (cam[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage three: magnitude of cz - c, the sign of the result, and the doubled depth.
  logic [MAG_W-1:0]         mag_q [2];
  logic [PW-1:0]            p_q [2];
  logic                     neg3_q [2], neg4_q [2], neg5_q [2];
  pvp_pkg::pvp_kind_e       kind3_q [2], kind4_q [2], kind5_q [2];
  logic                     sat5_q [2];
  logic [D_W-1:0]           r5_q [2];
  logic [QB-1:0]            plo5_q [2];
  logic [pvp_pkg::SIZE_W-1:0] size [2];
  logic [D_W-1:0]           d3_q, d4_q, d5_q;
  logic                     w3_q, w4_q, w5_q;
  logic [CAM_W-1:0]         dz;
  logic                     cz_neg;

  assign size[0] = width_q;
  assign size[1] = height_q;
  assign cz_neg  = cam[2][CAM_W-1];
  assign dz      = cz_neg ? CAM_W'(-cam[2]) : CAM_W'(cam[2]);

  for (genvar k = 0; k < 2; k++) begin : g_coord
    logic signed [CAM_W:0] diff;
    logic                  num_neg;
    logic [CAM_W:0]        adiff;
    logic                  sat_d;
    pvp_pkg::pvp_kind_e    kind_d;

    always_comb begin
      diff    = (CAM_W+1)'(cam[2]) - (CAM_W+1)'(cam[k]);
      num_neg = diff[CAM_W];
      adiff   = num_neg ? (CAM_W+1)'(-diff) : (CAM_W+1)'(diff);
      if (cam[2] != '0) begin
        kind_d = pvp_pkg::KIND_NORM;
      end else if (cam[k] == '0) begin
        kind_d = pvp_pkg::KIND_ZERO;
      end else if (!cam[k][CAM_W-1]) begin
        kind_d = pvp_pkg::KIND_MIN;
      end else begin
        kind_d = pvp_pkg::KIND_MAX;
      end
      // The pixel magnitude reaches 2^31 exactly when P / 2^31 >= 2|cz|.
      sat_d = CW'(p_q[k][PW-1:QB]) >= CW'(d4_q);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[k]   <= adiff[MAG_W-1:0];
        neg3_q[k]  <= num_neg ^ cz_neg;
        kind3_q[k] <= kind_d;
        p_q[k]     <= PW'(mag_q[k]) * PW'(size[k]);
        neg4_q[k]  <= neg3_q[k];
        kind4_q[k] <= kind3_q[k];
        sat5_q[k]  <= sat_d;
        r5_q[k]    <= D_W'(p_q[k][PW-1:QB]);
        plo5_q[k]  <= p_q[k][QB-1:0];
        neg5_q[k]  <= neg4_q[k];
        kind5_q[k] <= kind4_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_q <= last_in_i;
      l2_q <= l1_q;
      l3_q <= l2_q;
      l4_q <= l3_q;
      l5_q <= l4_q;
      d3_q <= {dz, 1'b0};
      w3_q <= cz_neg;
      d4_q <= d3_q;
      w4_q <= w3_q;
      d5_q <= d4_q;
      w5_q <= w4_q;
    end
  end

  // Divider chain.
  logic               cv [QB+1];
  pvp_pkg::pvp_side_t cs [QB+1];
  logic [D_W-1:0]     cd [QB+1];
  logic [D_W-1:0]     crx [QB+1];
  logic [D_W-1:0]     cry [QB+1];
  logic [QB-1:0]      cpx [QB+1];
  logic [QB-1:0]      cpy [QB+1];
  logic [QB-1:0]      cqx [QB+1];
  logic [QB-1:0]      cqy [QB+1];

  always_comb begin
    cs[0]        = '0;
    cs[0].kind_x = kind5_q[0];
    cs[0].kind_y = kind5_q[1];
    cs[0].neg_x  = neg5_q[0];
    cs[0].neg_y  = neg5_q[1];
    cs[0].sat_x  = sat5_q[0];
    cs[0].sat_y  = sat5_q[1];
    cs[0].white  = w5_q;
    cs[0].last   = l5_q;
  end

  assign cv[0]  = v5_q;
  assign cd[0]  = d5_q;
  assign crx[0] = r5_q[0];
  assign cry[0] = r5_q[1];
  assign cpx[0] = plo5_q[0];
  assign cpy[0] = plo5_q[1];
  assign cqx[0] = '0;
  assign cqy[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    pvp_div_cell #(
      .D_W (D_W),
      .QB  (QB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .side_i  (cs[i]),
      .d_i     (cd[i]),
      .rx_i    (crx[i]),
      .ry_i    (cry[i]),
      .px_i    (cpx[i]),
      .py_i    (cpy[i]),
      .qx_i    (cqx[i]),
      .qy_i    (cqy[i]),
      .valid_o (cv[i+1]),
      .side_o  (cs[i+1]),
      .d_o     (cd[i+1]),
      .rx_o    (crx[i+1]),
      .ry_o    (cry[i+1]),
      .px_o    (cpx[i+1]),
      .py_o    (cpy[i+1]),
      .qx_o    (cqx[i+1]),
      .qy_o    (cqy[i+1])
    );
  end

  // Output stage: sign, saturation and the zero depth cases.
  function automatic logic [pvp_pkg::PIX_W-1:0] finish(
    input pvp_pkg::pvp_kind_e kind,
    input logic               neg,
    input logic               sat,
    input logic [QB-1:0]      q
  );
    logic [pvp_pkg::PIX_W-1:0] qe;
    qe = pvp_pkg::PIX_W'(q);
    case (kind)
      pvp_pkg::KIND_ZERO: finish = '0;
      pvp_pkg::KIND_MIN:  finish = pvp_pkg::PIX_MIN;
      pvp_pkg::KIND_MAX:  finish = pvp_pkg::PIX_MAX;
      default: begin
        if (sat) begin
          finish = neg ? pvp_pkg::PIX_MIN : pvp_pkg::PIX_MAX;
        end else begin
          finish = neg ? (-qe) : qe;
        end
      end
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= cv[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_x_o  <= finish(cs[QB].kind_x, cs[QB].neg_x, cs[QB].sat_x, cqx[QB]);
      pixel_y_o  <= finish(cs[QB].kind_y, cs[QB].neg_y, cs[QB].sat_y, cqy[QB]);
      color_o    <= cs[QB].white ? pvp_pkg::COLOR_WHITE : pvp_pkg::COLOR_BLACK;
      last_out_o <= cs[QB].last;
    end
  end
endmodule
`default_nettype wire

[bench/tb_perspective_vertex_projector.sv]
// Self-checking bench for the perspective vertex projector: streams vertices
// through several matrix and display settings and compares every pixel word.
// Depends on pvp_pkg and perspective_vertex_projector.
`default_nettype none
module tb_perspective_vertex_projector;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [pvp_pkg::PIX_W-1:0] px;
    logic signed [pvp_pkg::PIX_W-1:0] py;
    logic [pvp_pkg::COLOR_W-1:0]      color;
    logic                             last;
  } pixel_word_t;

  class projection_scoreboard;
    logic [63:0]                matrix [6];
    logic [pvp_pkg::SIZE_W-1:0] width_px;
    logic [pvp_pkg::SIZE_W-1:0] height_px;
    pixel_word_t                pending [$];
    int                         errors;

    function new();
      matrix[0] = 64'h1_0000;
      matrix[1] = 64'd0;
      matrix[2] = 64'h1_0000 << 32;
      matrix[3] = 64'd0;
      matrix[4] = 64'd0;
      matrix[5] = 64'h1_0000;
      width_px  = pvp_pkg::WIDTH_RST;
      height_px = pvp_pkg::HEIGHT_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [pvp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        pvp_pkg::CFG_ROW0_A, pvp_pkg::CFG_ROW0_B, pvp_pkg::CFG_ROW1_A,
        pvp_pkg::CFG_ROW1_B, pvp_pkg::CFG_ROW2_A, pvp_pkg::CFG_ROW2_B: matrix[idx] = data;
        pvp_pkg::CFG_WIDTH:  width_px  = data[pvp_pkg::SIZE_W-1:0];
        pvp_pkg::CFG_HEIGHT: height_px = data[pvp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // One camera coordinate; the sum wraps in 64 bits.
    function longint camera(int r, longint vx, longint vy, longint vz);
      logic [63:0] a, b;
      longint acc;
      a = matrix[2*r];
      b = matrix[2*r+1];
      acc = longint'($signed(a[31:0])) * vx + longint'($signed(a[63:32])) * vy
          + longint'($signed(b[31:0])) * vz + longint'($signed(b[63:32]));
      return acc;
    endfunction

    // trunc((cz - c) * size / (2 * cz)), saturated to 32 signed bits; a zero cz gives fixed values.
    function logic [pvp_pkg::PIX_W-1:0] pixel(longint c, longint cz,
                                              logic [pvp_pkg::SIZE_W-1:0] size);
      logic [63:0]  mag, dz;
      logic [127:0] quo;
      logic         num_neg, neg, sat;
      if (cz == 0) begin
        if (c == 0) return '0;
        return (c > 0) ? pvp_pkg::PIX_MIN : pvp_pkg::PIX_MAX;
      end
      num_neg = cz < c;
      mag = num_neg ? 64'(c - cz) : 64'(cz - c);
      dz  = (cz < 0) ? 64'(-cz) : 64'(cz);
      quo = ({64'd0, mag} * {115'd0, size}) / {63'd0, dz, 1'b0};
      sat = quo[127:64] != 0;
      neg = num_neg != (cz < 0);
      if (!sat && quo == 0) return '0;
      if (neg) begin
        if (sat || quo[63:0] > 64'h8000_0000) return pvp_pkg::PIX_MIN;
        return -quo[31:0];
      end
      if (sat || quo[63:0] > 64'h7FFF_FFFF) return pvp_pkg::PIX_MAX;
      return quo[31:0];
    endfunction

    function void note_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic last);
      longint      cx, cy, cz;
      pixel_word_t w;
      cx = camera(0, x, y, z);
      cy = camera(1, x, y, z);
      cz = camera(2, x, y, z);
      w.px    = pixel(cx, cz, width_px);
      w.py    = pixel(cy, cz, height_px);
      w.color = (cz < 0) ? pvp_pkg::COLOR_WHITE : pvp_pkg::COLOR_BLACK;
      w.last  = last;
      pending.push_back(w);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, exp_v, act_v);
    endfunction

    function void check_word(pixel_word_t act);
      pixel_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $realtime, act);
        return;
      end
      e = pending.pop_front();
      if (act.px !== e.px) report("pixel_x", e.px, act.px);
      if (act.py !== e.py) report("pixel_y", e.py, act.py);
      if (act.color !== e.color) report("color", e.color, act.color);
      if (act.last !== e.last) report("last_out", e.last, act.last);
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, last_in_i;
  logic signed [15:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic out_valid_o, out_stall_i, last_out_o;
  logic signed [pvp_pkg::PIX_W-1:0] pixel_x_o, pixel_y_o;
  logic [pvp_pkg::COLOR_W-1:0] color_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [pvp_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;

  projection_scoreboard sb = new();
  bit quiet = 0;
  int unsigned cycles = 0;

  perspective_vertex_projector dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni)
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= !quiet && ($urandom_range(99) < 11);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({pixel_x_o, pixel_y_o, color_o, last_out_o});

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic last);
    in_valid_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    last_in_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vertex(x, y, z, last);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic random_vertex();
    logic signed [15:0] v [3];
    foreach (v[k])
      case ($urandom_range(5))
        0: v[k] = 16'sh8000;
        1: v[k] = 16'sh7FFF;
        2: v[k] = 16'($urandom_range(200)) - 16'sd100;
        default: v[k] = 16'($urandom);
      endcase
    send_vertex(v[0], v[1], v[2], 1'($urandom));
  endtask

  // Waits for the pipeline to drain before any register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  // Valid stays high so that writes follow back to back; the caller drops it.
  task automatic write_reg(logic [pvp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [31:0] coef(int unsigned span);
    return 32'($urandom_range(2 * span)) - 32'(span);
  endfunction

  initial begin
    in_valid_i = 0; vertex_x_i = 0; vertex_y_i = 0; vertex_z_i = 0; last_in_i = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset matrix: zero depth for vz of zero, both signs of depth otherwise.
    send_vertex(0, 0, 0, 0);
    send_vertex(5, -7, 0, 1);
    send_vertex(-5, 7, 0, 0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_vertex(16'sh7FFF, 16'sh8000, 1, 1);
    send_vertex(16'sh8000, 16'sh7FFF, -1, 0);
    send_vertex(3, 3, 3, 1);
    send_vertex(-1, 1, 100, 0);
    send_vertex(100, -100, -1, 1);
    send_vertex(0, 0, -5, 0);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      if (phase < 5) begin
        // Plausible view: small rotation terms, translation of either sign within +-2^30.
        for (int r = 0; r < 3; r++) begin
          write_reg(pvp_pkg::CFG_IDX_W'(2*r), {coef(131072), coef(131072)});
          write_reg(pvp_pkg::CFG_IDX_W'(2*r+1), {coef(1 << 30), coef(131072)});
        end
      end else begin
        for (int r = 0; r < 6; r++)
          write_reg(pvp_pkg::CFG_IDX_W'(r), {$urandom, $urandom});
      end
      case (phase)
        0: begin
          write_reg(pvp_pkg::CFG_WIDTH, 64'd1);
          write_reg(pvp_pkg::CFG_HEIGHT, 64'd4096);
        end
        1: begin
          write_reg(pvp_pkg::CFG_WIDTH, 64'd4096);
          write_reg(pvp_pkg::CFG_HEIGHT, 64'd1);
        end
        2: begin
          write_reg(pvp_pkg::CFG_WIDTH, 64'd0);
          write_reg(pvp_pkg::CFG_HEIGHT, 64'h1FFF);
        end
        default: begin
          write_reg(pvp_pkg::CFG_WIDTH, {$urandom, $urandom});
          write_reg(pvp_pkg::CFG_HEIGHT, {$urandom, $urandom});
        end
      endcase
      // Indexes past the register list must leave everything alone.
      write_reg(pvp_pkg::CFG_IDX_W'($urandom_range(15, 8)), {$urandom, $urandom});
      cfg_valid_i <= 1'b0;
      quiet = (phase == 3);
      repeat (160) random_vertex();
      quiet = 0;
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
src/pvp_pkg.sv
src/pvp_cam_row.sv
src/pvp_div_cell.sv
src/perspective_vertex_projector.sv
bench/tb_perspective_vertex_projector.sv
